// ===== design/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the swap step block
// Payload structs, wide-word widths and fee constants.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned FracBitsDef = 96;
  localparam int unsigned WW          = 320;   // product width
  localparam int unsigned PW          = 160;   // price width
  localparam int unsigned FeeW        = 20;
  localparam logic [FeeW-1:0] FeeDen  = 20'd1000000;
  localparam logic [FeeW-1:0] FeeMax  = 20'd999999;
  localparam logic [FeeW-1:0] FeeRst  = 20'd3000;

  typedef logic [WW-1:0] wide_t;

  typedef struct packed {
    logic [63:0]        price_lo;
    logic [63:0]        price_mid;
    logic [31:0]        price_hi;
    logic [63:0]        target_lo;
    logic [63:0]        target_mid;
    logic [31:0]        target_hi;
    logic [63:0]        liq_lo;
    logic signed [63:0] liq_hi;
    logic [63:0]        remain_lo;
    logic signed [63:0] remain_hi;
    logic               dir_down;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        new_price_lo;
    logic [63:0]        new_price_mid;
    logic [31:0]        new_price_hi;
    logic [63:0]        new_remain_lo;
    logic signed [63:0] new_remain_hi;
    logic [63:0]        calc_inc_lo;
    logic signed [63:0] calc_inc_hi;
    logic [63:0]        fee_lo;
    logic signed [63:0] fee_hi;
    logic [1:0]         step_kind;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_NOLIQ   = 2'd0,
    KIND_NOMOVE  = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_PARTIAL = 2'd3
  } kind_t;

  // request to the shared mul/div unit
  typedef struct packed {
    logic [PW-1:0] a;
    logic [PW-1:0] b;
    logic [PW-1:0] d;
    logic          neg;
    logic          up;
  } md_req_t;

  function automatic logic [127:0] neg128(input logic [127:0] x);
    neg128 = ~x + 128'd1;
  endfunction

  function automatic logic [127:0] abs128(input logic [127:0] x);
    abs128 = x[127] ? neg128(x) : x;
  endfunction

endpackage

// ===== design/lss_mul.sv =====
// ----------------------------------------------------------------------------
// lss_mul: shift-add multiplier
// 160x160 product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lss_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [lss_pkg::PW-1:0] a,
  input  logic [lss_pkg::PW-1:0] b,
  output logic              done,
  output lss_pkg::wide_t    prod
);
  import lss_pkg::*;

  logic [PW-1:0] mb_r;
  wide_t         ma_r, acc_r;
  logic [7:0]    cnt_r;
  logic          busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ma_r   <= wide_t'(a);
        mb_r   <= b;
        acc_r  <= '0;
        cnt_r  <= 8'(PW);
      end else if (busy_r) begin
        if (mb_r[0]) acc_r <= acc_r + ma_r;
        ma_r  <= ma_r << 1;
        mb_r  <= mb_r >> 1;
        cnt_r <= cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ===== design/lss_div.sv =====
// ----------------------------------------------------------------------------
// lss_div: restoring divider
// 320-by-160 long division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lss_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  lss_pkg::wide_t         num,
  input  logic [lss_pkg::PW-1:0] den,
  output logic                   done,
  output lss_pkg::wide_t         quo,
  output logic                   rem_nz
);
  import lss_pkg::*;

  wide_t         n_r, q_r;
  logic [PW:0]   r_r;
  logic [PW-1:0] d_r;
  logic [8:0]    cnt_r;
  logic          busy_r, done_r;
  logic [PW+1:0] sh, diff;

  always_comb begin
    sh   = {r_r, n_r[WW-1]};
    diff = sh - {2'b00, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= num;
        d_r    <= den;
        r_r    <= '0;
        q_r    <= '0;
        cnt_r  <= 9'(WW);
      end else if (busy_r) begin
        n_r <= n_r << 1;
        if (!diff[PW+1]) begin
          r_r <= diff[PW:0];
          q_r <= {q_r[WW-2:0], 1'b1};
        end else begin
          r_r <= sh[PW:0];
          q_r <= {q_r[WW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 9'd1;
        if (cnt_r == 9'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign quo    = q_r;
  assign rem_nz = |r_r;
endmodule

// ===== design/lss_muldiv.sv =====
// ----------------------------------------------------------------------------
// lss_muldiv: shared mul_div unit
// floor or ceil of a*b/d with sign applied; zero divisor gives zero.
// ----------------------------------------------------------------------------
module lss_muldiv (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  lss_pkg::md_req_t        req,
  output logic                    done,
  output logic [lss_pkg::PW-1:0]  res
);
  import lss_pkg::*;

  logic    mul_done, div_done, div_nz;
  wide_t   prod, quo;
  md_req_t req_r;
  logic    zero_r, zdone_r;
  logic [PW-1:0] q_adj;

  lss_mul u_mul (
    .clk, .rst_n, .start(start && (req.d != '0)), .a(req.a), .b(req.b),
    .done(mul_done), .prod(prod)
  );

  lss_div u_div (
    .clk, .rst_n, .start(mul_done), .num(prod), .den(req_r.d),
    .done(div_done), .quo(quo), .rem_nz(div_nz)
  );

  always_comb begin
    q_adj = quo[PW-1:0];
    if (req_r.up && !req_r.neg && div_nz) q_adj = q_adj + PW'(1);
    if (req_r.neg) q_adj = ~q_adj + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zdone_r <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      zdone_r <= start && (req.d == '0);
      if (start) begin
        req_r  <= req;
        zero_r <= (req.d == '0);
      end
    end
  end

  assign done = div_done || zdone_r;
  assign res  = zero_r ? '0 : q_adj;
endmodule

// ===== design/liquidity_swap_step.sv =====
// ----------------------------------------------------------------------------
// liquidity_swap_step: one concentrated-liquidity swap step
// Sequencer around one shared multiply/divide unit.
// ----------------------------------------------------------------------------
// Sequencing: no-liquidity/no-move items finish without the mul_div unit; a
//   moving step runs 4 to 8 mul_div ops, each a multiply then a divide (a zero
//   divisor skips both and gives zero). One item at a time.
// Throughput: next item accepted once the result has been taken.
// Reset: synchronous active low; fee register returns to 3000, block idle.
module liquidity_swap_step #(
  parameter int unsigned FRAC_BITS = lss_pkg::FracBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lss_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lss_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [lss_pkg::FeeW-1:0]      cfg_fee_ppm
);
  import lss_pkg::*;

  localparam logic [PW-1:0] QOne = PW'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_OP, S_WAIT, S_PICK, S_FEE, S_FIN, S_OUT
  } state_t;

  // op codes for the ordered mul_div steps
  typedef enum logic [3:0] {
    OP_MAXOUT_A, OP_MAXOUT_B, OP_MAXIN_A, OP_MAXIN_B, OP_AFTER,
    OP_RATIO, OP_OTHER, OP_FEE, OP_STEP
  } op_t;

  state_t  state_r;
  op_t     op_r;
  logic [FeeW-1:0] fee_cfg_r, fp_r;
  logic [PW-1:0]   price_r, target_r, delta_r, step_r;
  logic [127:0]    liq_r, rem_r, max_in_r, max_out_r, ain_r, aout_r, tmp_r;
  logic [127:0]    ratio_r, after_r, fee_r;
  logic            z_r, partial_r, exin_r;
  out_item_t       out_r;

  md_req_t        req;
  logic           md_start, md_done;
  logic [PW-1:0]  md_res;
  logic [127:0]   r128;

  lss_muldiv u_md (
    .clk, .rst_n, .start(md_start), .req(req), .done(md_done), .res(md_res)
  );

  assign r128 = md_res[127:0];

  // signed 128 ops as operands: magnitude, sign
  function automatic logic [PW-1:0] mag(input logic [127:0] x);
    mag = PW'(abs128(x));
  endfunction

  // operand select per op
  always_comb begin
    req = '0;
    unique case (op_r)
      OP_MAXOUT_A: begin // z: L*D/Q ; !z: L*D/price
        req.a = mag(liq_r); req.b = delta_r; req.d = z_r ? QOne : price_r;
      end
      OP_MAXOUT_B: begin // !z only: tmp*Q/target
        req.a = mag(tmp_r); req.b = QOne; req.d = target_r;
        req.neg = tmp_r[127] && (target_r != '0);
      end
      OP_MAXIN_A: begin // z: L*D/target ; !z: L*D/Q up
        req.a = mag(liq_r); req.b = delta_r; req.d = z_r ? target_r : QOne;
        req.up = !z_r;
      end
      OP_MAXIN_B: begin // z only: tmp*Q/price up
        req.a = mag(tmp_r); req.b = QOne; req.d = price_r; req.up = 1'b1;
        req.neg = tmp_r[127] && (price_r != '0);
      end
      OP_AFTER: begin
        req.a = mag(rem_r); req.b = PW'(FeeDen - fp_r); req.d = PW'(FeeDen);
        req.neg = rem_r[127];
      end
      OP_RATIO: begin
        req.a = exin_r ? mag(ain_r) : mag(aout_r); req.b = QOne;
        req.d = exin_r ? mag(max_in_r) : mag(max_out_r);
        req.neg = (exin_r ? (ain_r[127] ^ max_in_r[127])
                          : (aout_r[127] ^ max_out_r[127])) && (req.d != '0);
      end
      OP_OTHER: begin
        req.a = exin_r ? mag(max_out_r) : mag(max_in_r); req.b = mag(ratio_r);
        req.d = QOne; req.up = !exin_r;
        req.neg = exin_r ? (max_out_r[127] ^ ratio_r[127])
                         : (max_in_r[127] ^ ratio_r[127]);
      end
      OP_FEE: begin
        req.a = mag(ain_r); req.b = PW'(fp_r); req.d = PW'(FeeDen - fp_r);
        req.up = 1'b1; req.neg = ain_r[127];
      end
      OP_STEP: begin
        req.a = delta_r; req.b = mag(ratio_r); req.d = QOne;
        req.neg = ratio_r[127];
      end
      default: req = '0;
    endcase
  end

  assign md_start = (state_r == S_OP);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_item  = out_r;

  logic [127:0] absrem, sum_af;
  logic         ge_in, ge_out;
  always_comb begin
    absrem = abs128(rem_r);
    ge_in  = $signed(after_r) >= $signed(max_in_r);
    ge_out = $signed(absrem) >= $signed(max_out_r);
    sum_af = ain_r + fee_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fee_cfg_r <= FeeRst;
      op_r      <= OP_MAXOUT_A;
    end else begin
      if (cfg_we) fee_cfg_r <= cfg_fee_ppm;
      case (state_r)
        S_IDLE: if (in_valid) begin
          price_r  <= {in_item.price_hi, in_item.price_mid, in_item.price_lo};
          target_r <= {in_item.target_hi, in_item.target_mid, in_item.target_lo};
          liq_r    <= {in_item.liq_hi, in_item.liq_lo};
          rem_r    <= {in_item.remain_hi, in_item.remain_lo};
          z_r      <= in_item.dir_down;
          fp_r     <= (fee_cfg_r > FeeMax) ? FeeMax : fee_cfg_r;
          state_r  <= S_DECIDE;
        end
        S_DECIDE: begin
          out_r.new_remain_lo <= rem_r[63:0];
          out_r.new_remain_hi <= rem_r[127:64];
          out_r.calc_inc_lo   <= '0;
          out_r.calc_inc_hi   <= '0;
          out_r.fee_lo        <= '0;
          out_r.fee_hi        <= '0;
          delta_r   <= z_r ? price_r - target_r : target_r - price_r;
          exin_r    <= !rem_r[127] && (rem_r != '0);
          partial_r <= 1'b0;
          ratio_r   <= '0;
          if (liq_r[127] || liq_r == '0) begin
            {out_r.new_price_hi, out_r.new_price_mid, out_r.new_price_lo} <= target_r;
            out_r.step_kind <= KIND_NOLIQ;
            state_r <= S_OUT;
          end else if (z_r ? (price_r <= target_r) : (price_r >= target_r)) begin
            {out_r.new_price_hi, out_r.new_price_mid, out_r.new_price_lo} <= price_r;
            out_r.step_kind <= KIND_NOMOVE;
            state_r <= S_OUT;
          end else begin
            op_r    <= OP_MAXOUT_A;
            state_r <= S_OP;
          end
        end
        S_OP: state_r <= S_WAIT;
        S_WAIT: if (md_done) begin
          state_r <= S_OP;
          case (op_r)
            OP_MAXOUT_A: begin
              if (z_r) begin max_out_r <= r128; op_r <= OP_MAXIN_A; end
              else begin tmp_r <= r128; op_r <= OP_MAXOUT_B; end
            end
            OP_MAXOUT_B: begin max_out_r <= r128; op_r <= OP_MAXIN_A; end
            OP_MAXIN_A: begin
              if (z_r) begin tmp_r <= r128; op_r <= OP_MAXIN_B; end
              else begin
                max_in_r <= r128;
                op_r <= OP_AFTER;
                if (!exin_r) state_r <= S_PICK;
              end
            end
            OP_MAXIN_B: begin
              max_in_r <= r128;
              op_r <= OP_AFTER;
              if (!exin_r) state_r <= S_PICK;
            end
            OP_AFTER: begin after_r <= r128; state_r <= S_PICK; end
            OP_RATIO: begin ratio_r <= r128; op_r <= OP_OTHER; end
            OP_OTHER: begin
              if (exin_r) aout_r <= r128; else ain_r <= r128;
              op_r <= OP_FEE;
            end
            OP_FEE: begin fee_r <= r128; state_r <= S_FEE; end
            OP_STEP: begin step_r <= md_res; state_r <= S_FIN; end
            default: state_r <= S_IDLE;
          endcase
        end
        S_PICK: begin
          // full step or partial by ratio
          if (exin_r) begin
            if (ge_in) begin
              ain_r <= max_in_r; aout_r <= max_out_r; op_r <= OP_FEE;
            end else begin
              ain_r <= after_r; partial_r <= 1'b1; op_r <= OP_RATIO;
            end
          end else begin
            if (ge_out) begin
              aout_r <= max_out_r; ain_r <= max_in_r; op_r <= OP_FEE;
            end else begin
              aout_r <= absrem; partial_r <= 1'b1; op_r <= OP_RATIO;
            end
          end
          state_r <= S_OP;
        end
        S_FEE: begin
          out_r.fee_lo <= fee_r[63:0];
          out_r.fee_hi <= fee_r[127:64];
          if (exin_r) begin
            {out_r.new_remain_hi, out_r.new_remain_lo} <= rem_r - sum_af;
            {out_r.calc_inc_hi, out_r.calc_inc_lo}     <= aout_r;
          end else begin
            {out_r.new_remain_hi, out_r.new_remain_lo} <= rem_r + aout_r;
            {out_r.calc_inc_hi, out_r.calc_inc_lo}     <= sum_af;
          end
          if (partial_r) begin
            op_r <= OP_STEP; state_r <= S_OP;
          end else begin
            {out_r.new_price_hi, out_r.new_price_mid, out_r.new_price_lo} <= target_r;
            out_r.step_kind <= KIND_FULL;
            state_r <= S_OUT;
          end
        end
        S_FIN: begin
          {out_r.new_price_hi, out_r.new_price_mid, out_r.new_price_lo} <=
            z_r ? price_r - step_r : price_r + step_r;
          out_r.step_kind <= KIND_PARTIAL;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/sv/liquidity_swap_step_tb.sv =====
// ----------------------------------------------------------------------------
// liquidity_swap_step_tb: self-checking bench for the swap step block
// Drives directed and random swap steps through the valid/ready input channel
// under random bursts and output stalls. Each result is checked field by field
// against a bit-exact fixed-point predictor that runs on wide vectors.
// ----------------------------------------------------------------------------
module liquidity_swap_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  typedef bit [319:0] w320_t;
  typedef bit [159:0] price_t;
  typedef bit [127:0] amt_t;
  // magnitude and sign of one mul_div operand
  typedef struct {
    w320_t m;
    bit    n;
  } mag_t;

  localparam price_t QONE = price_t'(1) << FracBitsDef;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic [FeeW-1:0] cfg_fee_ppm;

  // fee as the block holds it; tracks every register write
  bit [FeeW-1:0] fee_shadow = FeeRst;
  out_item_t     swap_expect_q[$];
  int            n_errors = 0;

  liquidity_swap_step dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_fee_ppm  (cfg_fee_ppm)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Swap step predictor
  // --------------------------------------------------------------------------
  function automatic mag_t from_amt(amt_t x);
    mag_t o;
    o.n = x[127];
    o.m = w320_t'(x[127] ? amt_t'(-x) : x);  // most negative gives 2^127
    return o;
  endfunction

  function automatic mag_t from_price(price_t x);
    mag_t o;
    o.n = 1'b0;
    o.m = w320_t'(x);
    return o;
  endfunction

  // a*b/d on magnitudes; zero divisor gives 0, round up only when non-negative
  function automatic w320_t mul_div_mag(mag_t a, mag_t b, mag_t d, bit up, output bit neg);
    w320_t p;
    w320_t q;
    neg = 1'b0;
    if (d.m == 0) return '0;
    neg = a.n ^ b.n ^ d.n;
    p = a.m * b.m;
    q = p / d.m;
    if (up && !neg && (p % d.m) != 0) q = q + 1;
    return q;
  endfunction

  function automatic amt_t mul_div_amt(mag_t a, mag_t b, mag_t d, bit up);
    bit    neg;
    amt_t  r;
    r = amt_t'(mul_div_mag(a, b, d, up, neg));
    return neg ? amt_t'(-r) : r;
  endfunction

  function automatic price_t mul_div_price(mag_t a, mag_t b, mag_t d);
    bit     neg;
    price_t r;
    r = price_t'(mul_div_mag(a, b, d, 1'b0, neg));
    return neg ? price_t'(-r) : r;
  endfunction

  function automatic out_item_t predict_swap(in_item_t it, bit [FeeW-1:0] fee_reg);
    price_t    price, target, np, delta, shift;
    amt_t      liq, rem, nr, calc, fee, max_in, max_out, ain, aout, ratio, after, absr;
    mag_t      qm, lm, dm, fpo, cden;
    bit        z, partial, spend_in;
    bit [19:0] fp;
    kind_t     kind;
    out_item_t o;
    price  = {it.price_hi, it.price_mid, it.price_lo};
    target = {it.target_hi, it.target_mid, it.target_lo};
    liq    = {it.liq_hi, it.liq_lo};
    rem    = {it.remain_hi, it.remain_lo};
    z      = it.dir_down;
    np     = price;
    nr     = rem;
    calc   = '0;
    fee    = '0;
    if (liq[127] || liq == 0) begin
      np   = target;
      kind = KIND_NOLIQ;
    end else if (z ? (price <= target) : (price >= target)) begin
      kind = KIND_NOMOVE;
    end else begin
      delta   = z ? price - target : target - price;
      qm      = from_price(QONE);
      lm      = from_amt(liq);
      dm      = from_price(delta);
      fp      = (fee_reg > FeeMax) ? FeeMax : fee_reg;
      fpo     = from_price(price_t'(fp));
      cden    = from_price(price_t'(FeeDen - fp));
      partial = 1'b0;
      ratio   = '0;
      if (z) begin
        max_out = mul_div_amt(lm, dm, qm, 1'b0);
        max_in  = mul_div_amt(from_amt(mul_div_amt(lm, dm, from_price(target), 1'b0)),
                              qm, from_price(price), 1'b1);
      end else begin
        max_out = mul_div_amt(from_amt(mul_div_amt(lm, dm, from_price(price), 1'b0)),
                              qm, from_price(target), 1'b0);
        max_in  = mul_div_amt(lm, dm, qm, 1'b1);
      end
      spend_in = !rem[127] && rem != 0;
      if (spend_in) begin
        after = mul_div_amt(from_amt(rem), cden, from_price(price_t'(FeeDen)), 1'b0);
        if ($signed(after) >= $signed(max_in)) begin
          ain  = max_in;
          aout = max_out;
        end else begin
          partial = 1'b1;
          ain     = after;
          ratio   = mul_div_amt(from_amt(ain), qm, from_amt(max_in), 1'b0);
          aout    = mul_div_amt(from_amt(max_out), from_amt(ratio), qm, 1'b0);
        end
        fee  = mul_div_amt(from_amt(ain), fpo, cden, 1'b1);
        nr   = rem - (ain + fee);
        calc = aout;
      end else begin
        absr = rem[127] ? amt_t'(-rem) : rem;
        if ($signed(absr) >= $signed(max_out)) begin
          aout = max_out;
          ain  = max_in;
        end else begin
          partial = 1'b1;
          aout    = absr;
          ratio   = mul_div_amt(from_amt(aout), qm, from_amt(max_out), 1'b0);
          ain     = mul_div_amt(from_amt(max_in), from_amt(ratio), qm, 1'b1);
        end
        fee  = mul_div_amt(from_amt(ain), fpo, cden, 1'b1);
        nr   = rem + aout;
        calc = ain + fee;
      end
      if (partial) begin
        shift = mul_div_price(dm, from_amt(ratio), qm);
        np    = z ? price - shift : price + shift;
        kind  = KIND_PARTIAL;
      end else begin
        np   = target;
        kind = KIND_FULL;
      end
    end
    {o.new_price_hi, o.new_price_mid, o.new_price_lo} = np;
    {o.new_remain_hi, o.new_remain_lo} = nr;
    {o.calc_inc_hi, o.calc_inc_lo}     = calc;
    {o.fee_hi, o.fee_lo}               = fee;
    o.step_kind = kind;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input accept, compare on output accept
  // --------------------------------------------------------------------------
  task automatic check_field(string name, bit [159:0] exp_v, bit [159:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (in_valid && in_ready)
        swap_expect_q.push_back(predict_swap(in_item, fee_shadow));
      if (out_valid && out_ready) begin
        if (swap_expect_q.size() == 0) begin
          n_errors++;
          $display("%0t ns: unexpected result, expected none, got %0h", $time, out_item);
        end else begin
          e = swap_expect_q.pop_front();
          check_field("new_price_lo", e.new_price_lo, out_item.new_price_lo);
          check_field("new_price_mid", e.new_price_mid, out_item.new_price_mid);
          check_field("new_price_hi", e.new_price_hi, out_item.new_price_hi);
          check_field("new_remain_lo", e.new_remain_lo, out_item.new_remain_lo);
          check_field("new_remain_hi", e.new_remain_hi, out_item.new_remain_hi);
          check_field("calc_inc_lo", e.calc_inc_lo, out_item.calc_inc_lo);
          check_field("calc_inc_hi", e.calc_inc_hi, out_item.calc_inc_hi);
          check_field("fee_lo", e.fee_lo, out_item.fee_lo);
          check_field("fee_hi", e.fee_hi, out_item.fee_hi);
          check_field("step_kind", e.step_kind, out_item.step_kind);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stalls: a rotating pattern, re-rolled each time the 6-bit counter
  // wraps; some windows never stall at all.
  // --------------------------------------------------------------------------
  bit [15:0] stall_pat = 16'hFFFF;
  bit [5:0]  stall_cnt = '0;

  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 6'd1;
    if (stall_cnt == 0)
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    else
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    out_ready <= stall_pat[0];
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  int burst_left = 0;

  // valid stays up inside a burst; the next item replaces the accepted one
  // in the same step, so valid drops only at a gap
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left -= 1;
  endtask

  task automatic send_step(price_t p, price_t t, amt_t l, amt_t r, bit z);
    in_item_t it;
    {it.price_hi, it.price_mid, it.price_lo}    = p;
    {it.target_hi, it.target_mid, it.target_lo} = t;
    {it.liq_hi, it.liq_lo}                      = l;
    {it.remain_hi, it.remain_lo}                = r;
    it.dir_down                                 = z;
    send_item(it);
  endtask

  // close the burst, wait for every result, then let the block settle
  // before a register write
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (swap_expect_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_fee(bit [FeeW-1:0] v);
    wait_drained();
    cfg_fee_ppm <= v;
    cfg_we      <= 1'b1;
    @(negedge clk);
    cfg_we     <= 1'b0;
    fee_shadow = v;
  endtask

  function automatic price_t rand_wide(int nbits);
    price_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return (nbits <= 0) ? '0 : r >> (160 - nbits);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  localparam price_t P1   = QONE;            // price 1.0
  localparam price_t P2   = QONE << 1;       // price 2.0
  localparam amt_t   LIQ  = amt_t'(1) << 70;
  localparam amt_t   MOST_NEG = amt_t'(1) << 127;

  task automatic test_no_liquidity();
    send_step(P1, P2, '0, 128'd1000, 1'b0);
    send_step(P2, P1, MOST_NEG, -128'sd5, 1'b1);
    send_step('1, '0, '1, '1, 1'b1);
  endtask

  task automatic test_no_move();
    send_step(P1, P1, LIQ, 128'd1000, 1'b0);
    send_step(P1, P1, LIQ, 128'd1000, 1'b1);
    send_step(P2, P1, LIQ, -128'sd77, 1'b0);
    send_step(P1, P2, LIQ, 128'd77, 1'b1);
  endtask

  task automatic test_full_step();
    send_step(P1, P2, LIQ, amt_t'(1) << 100, 1'b0);     // exact in, rising
    send_step(P2, P1, LIQ, amt_t'(1) << 100, 1'b1);     // exact in, falling
    send_step(P1, P2, LIQ, -(amt_t'(1) << 100), 1'b0);  // exact out
    send_step(P2, P1, LIQ, MOST_NEG, 1'b1);             // most negative amount
    send_step(P2, '0, LIQ, 128'd12345, 1'b1);           // zero target divisor
    send_step('0, P1, LIQ, 128'd12345, 1'b0);           // zero price divisor
  endtask

  task automatic test_partial_step();
    send_step(P1, P2, LIQ, 128'd1000000, 1'b0);
    send_step(P2, P1, LIQ, 128'd999, 1'b1);
    send_step(P1, P2, LIQ, -128'sd123456789, 1'b0);
    send_step(P2, P1, LIQ, '0, 1'b1);                   // zero remaining
    send_step('1, 160'd1, {1'b0, {127{1'b1}}}, {1'b0, {127{1'b1}}}, 1'b1);
    send_step(160'd1, '1, {1'b0, {127{1'b1}}}, MOST_NEG, 1'b0);
  endtask

  task automatic test_fee_extremes();
    bit [FeeW-1:0] fees[4] = '{20'd0, FeeMax, 20'hFFFFF, 20'd1};
    foreach (fees[i]) begin
      write_fee(fees[i]);
      send_step(P1, P2, LIQ, 128'd5000000, 1'b0);
      send_step(P2, P1, LIQ, -(amt_t'(1) << 100), 1'b1);
    end
  endtask

  task automatic test_random_steps(int n_items);
    price_t p, t, d;
    amt_t   l, r;
    bit     z;
    int     sel;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        sel = $urandom_range(0, 3);
        write_fee(sel == 0 ? FeeW'($urandom) :
                  sel == 1 ? FeeW'($urandom_range(0, 999999)) : FeeW'($urandom_range(0, 10000)));
      end
      sel = $urandom_range(0, 19);
      z   = $urandom_range(0, 1);
      if (sel < 2) begin
        // noise: every field fully random
        p = rand_wide(160);
        t = rand_wide(160);
        l = amt_t'(rand_wide(128));
        r = amt_t'(rand_wide(128));
      end else begin
        p = rand_wide($urandom_range(80, 110));
        d = rand_wide($urandom_range(1, 100));
        if (z) t = (d < p) ? p - d : '0;
        else   t = p + d;
        l = amt_t'(rand_wide($urandom_range(1, 120)));
        r = amt_t'(rand_wide($urandom_range(0, 110)));
        if ($urandom_range(0, 1)) r = -r;
        if (sel == 2) l = -l;                 // no liquidity
        if (sel == 3) begin                   // no move
          d = t;
          t = p;
          p = d;
        end
      end
      send_step(p, t, l, r, z);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_fee_ppm  = '0;
    out_ready    = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_no_liquidity();
    test_no_move();
    test_full_step();
    test_partial_step();
    test_fee_extremes();
    test_random_steps(215);

    wait_drained();
    repeat (20) @(negedge clk);
    if (n_errors == 0 && swap_expect_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // time for the slowest run (~245 items plus stalls and gaps), taken 5x over
  initial begin
    #70ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
